// File: rtl/text_console_char_handler_defines.svh
// Assertion helpers shared by the console RTL.
`ifndef TEXT_CONSOLE_CHAR_HANDLER_DEFINES_SVH
`define TEXT_CONSOLE_CHAR_HANDLER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define TCC_ASSERT_IMP(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define TCC_ASSERT_NXT(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/tcc_pkg.sv
package tcc_pkg;

  localparam int MAX_COLS  = 128;
  localparam int MAX_ROWS  = 64;
  localparam int COL_W     = $clog2(MAX_COLS);
  localparam int ROW_W     = $clog2(MAX_ROWS);
  localparam int ADDR_W    = COL_W + ROW_W;
  localparam int SH_W      = 2 * ROW_W;
  localparam int STEP_W    = $clog2(ROW_W + 1);

  localparam int KIND_W    = 2;
  localparam int CHAR_W    = 8;
  localparam int NCOLS_W   = 8;
  localparam int NROWS_W   = 7;
  localparam int CFG_W     = 8;
  localparam int CFG_IDX_W = 1;

  localparam logic [CHAR_W-1:0] CH_BLANK = 8'h20;
  localparam logic [CHAR_W-1:0] CH_NL    = 8'd10;
  localparam logic [CHAR_W-1:0] CH_CR    = 8'd13;
  localparam logic [CHAR_W-1:0] CH_BS    = 8'd8;

  localparam logic [NCOLS_W-1:0] NUM_COLS_RST = 8'd80;
  localparam logic [NROWS_W-1:0] NUM_ROWS_RST = 7'd40;

  typedef enum logic [KIND_W-1:0] {
    KIND_TYPE  = 2'd0,
    KIND_CLEAR = 2'd1,
    KIND_READ  = 2'd2,
    KIND_NOP   = 2'd3
  } kind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_NUM_COLS = 1'b0,
    CFG_NUM_ROWS = 1'b1
  } cfg_idx_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MOD,
    S_EXEC,
    S_SWEEP,
    S_READ
  } state_t;

  typedef struct packed {
    logic load;
    logic mod_step;
    logic exec;
    logic fill;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic out_free;
    logic mod_need;
    logic mod_last;
    logic need_fill;
    logic need_read;
    logic fill_last;
  } sts_t;

endpackage

// File: rtl/tcc_if.sv
interface tcc_req_if;
  import tcc_pkg::*;
  logic                valid;
  logic                ready;
  logic [KIND_W-1:0]   kind;
  logic [CHAR_W-1:0]   char_code;
  logic [ROW_W-1:0]    read_row;
  logic [COL_W-1:0]    read_col;

  modport source (output valid, kind, char_code, read_row, read_col, input ready);
  modport sink   (input valid, kind, char_code, read_row, read_col, output ready);
endinterface

interface tcc_rsp_if;
  import tcc_pkg::*;
  logic                valid;
  logic                ready;
  logic [COL_W-1:0]    cursor_col;
  logic [ROW_W-1:0]    cursor_row;
  logic                scrolled;
  logic [CHAR_W-1:0]   read_char;

  modport source (output valid, cursor_col, cursor_row, scrolled, read_char, input ready);
  modport sink   (input valid, cursor_col, cursor_row, scrolled, read_char, output ready);
endinterface

// File: rtl/text_console_char_handler.sv
// Flow: a request is accepted in S_IDLE and executed in S_EXEC; reads add S_READ
// (registered store read); typing a printable character into a row not yet written since
// reset, clear or scroll adds S_SWEEP while all MAX_COLS cells of that row are swept to blanks.
// S_MOD comes before S_EXEC when the ring offset is at or above the row count (offset reduction loop).
// Acceptance: a new request is taken only once the last is finished; a finished result waits in the output register.
// Reset: cursor, offset, registers (80 cols, 40 rows) restored; row flags make the store blank.
module text_console_char_handler
  import tcc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  tcc_req_if.sink              req,
  tcc_rsp_if.source            rsp,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  cmd_t cmd;
  sts_t sts;

  tcc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  tcc_dpath u_dpath (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .kind           (req.kind),
    .char_code      (req.char_code),
    .read_row       (req.read_row),
    .read_col       (req.read_col),
    .cmd            (cmd),
    .sts            (sts),
    .rsp_valid      (rsp.valid),
    .rsp_ready      (rsp.ready),
    .rsp_cursor_col (rsp.cursor_col),
    .rsp_cursor_row (rsp.cursor_row),
    .rsp_scrolled   (rsp.scrolled),
    .rsp_read_char  (rsp.read_char)
  );

endmodule

// File: rtl/tcc_ctrl.sv
`include "text_console_char_handler_defines.svh"

module tcc_ctrl
  import tcc_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    req_ready  = 1'b0;
    unique case (state)
      S_IDLE: begin
        req_ready = sts.out_free;
        if (req_valid && sts.out_free) begin
          cmd.load   = 1'b1;
          state_next = sts.mod_need ? S_MOD : S_EXEC;
        end
      end
      S_MOD: begin
        cmd.mod_step = 1'b1;
        if (sts.mod_last) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec = 1'b1;
        if (sts.need_fill) begin
          state_next = S_SWEEP;
        end else if (sts.need_read) begin
          state_next = S_READ;
        end else begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_SWEEP: begin
        cmd.fill = 1'b1;
        if (sts.fill_last) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_READ: begin
        cmd.finish = 1'b1;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  `TCC_ASSERT_NXT(a_accept_starts, clk, rst, state == S_IDLE && req_valid && req_ready, state == S_MOD || state == S_EXEC, "accepted request did not start")
  `TCC_ASSERT_IMP(a_sweep_entry, clk, rst, state == S_SWEEP, $past(state) == S_SWEEP || $past(state) == S_EXEC, "row sweep entered out of order")
  `TCC_ASSERT_NXT(a_finish_idle, clk, rst, cmd.finish, state == S_IDLE, "finish did not return to idle")

endmodule

// File: rtl/tcc_dpath.sv
`include "text_console_char_handler_defines.svh"

module tcc_dpath
  import tcc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic [KIND_W-1:0]    kind,
  input  logic [CHAR_W-1:0]    char_code,
  input  logic [ROW_W-1:0]     read_row,
  input  logic [COL_W-1:0]     read_col,
  input  cmd_t                 cmd,
  output sts_t                 sts,
  output logic                 rsp_valid,
  input  logic                 rsp_ready,
  output logic [COL_W-1:0]     rsp_cursor_col,
  output logic [ROW_W-1:0]     rsp_cursor_row,
  output logic                 rsp_scrolled,
  output logic [CHAR_W-1:0]    rsp_read_char
);

  // configuration and console state
  logic [NCOLS_W-1:0]  num_cols;
  logic [NROWS_W-1:0]  num_rows;
  logic [COL_W-1:0]    cur_col;
  logic [ROW_W-1:0]    cur_row;
  logic [ROW_W-1:0]    top;
  logic [MAX_ROWS-1:0] row_valid;
  logic [MAX_ROWS-1:0] row_valid_next;

  // latched request
  kind_t               it_kind;
  logic [CHAR_W-1:0]   it_char;
  logic [ROW_W-1:0]    it_rrow;
  logic [COL_W-1:0]    it_rcol;

  // offset reduction and row sweep
  logic [ROW_W-1:0]    rem;
  logic [STEP_W-1:0]   step;
  logic [ROW_W-1:0]    wr_row;
  logic [COL_W-1:0]    wr_col;
  logic [CHAR_W-1:0]   wr_char;
  logic [COL_W-1:0]    fill_cnt;

  logic [CHAR_W-1:0]   mem [MAX_ROWS*MAX_COLS];
  logic [CHAR_W-1:0]   mem_q;
  logic                mem_we;
  logic [ADDR_W-1:0]   mem_waddr;
  logic [CHAR_W-1:0]   mem_wdata;
  logic                mem_rd;

  logic [COL_W:0]      cols;
  logic [ROW_W:0]      rows;
  logic [COL_W-1:0]    col_c;
  logic [ROW_W-1:0]    row_c;
  logic                is_nl, is_cr, is_bs, is_print;
  logic [ROW_W-1:0]    vrow;
  logic [ROW_W:0]      vsum;
  logic [ROW_W-1:0]    phys;
  logic [COL_W-1:0]    bs_col;
  logic [COL_W-1:0]    tcol;
  logic                row_ok;
  logic                rd_in_range;
  logic                single_wr;
  logic [SH_W-1:0]     shifted;

  logic [COL_W:0]      col_inc;
  logic [ROW_W:0]      row_inc;
  logic [ROW_W:0]      top_inc;
  logic [COL_W-1:0]    nxt_col;
  logic [ROW_W-1:0]    nxt_row;
  logic [ROW_W-1:0]    nxt_top;
  logic                nl_req;
  logic                scroll;
  logic [CHAR_W-1:0]   rd_val;

  // out-of-range register values saturate
  always_comb begin
    if (num_cols == '0) begin
      cols = (COL_W+1)'(1);
    end else if (num_cols > MAX_COLS) begin
      cols = (COL_W+1)'(MAX_COLS);
    end else begin
      cols = (COL_W+1)'(num_cols);
    end
    if (num_rows == '0) begin
      rows = (ROW_W+1)'(1);
    end else if (num_rows > MAX_ROWS) begin
      rows = (ROW_W+1)'(MAX_ROWS);
    end else begin
      rows = (ROW_W+1)'(num_rows);
    end
  end

  assign col_c = ({1'b0, cur_col} >= cols) ? COL_W'(cols - 1'b1) : cur_col;
  assign row_c = ({1'b0, cur_row} >= rows) ? ROW_W'(rows - 1'b1) : cur_row;

  assign is_nl    = (it_char == CH_NL);
  assign is_cr    = (it_char == CH_CR);
  assign is_bs    = (it_char == CH_BS);
  assign is_print = !(is_nl || is_cr || is_bs);

  // visible row -> physical row; rem is already below rows here
  assign vrow = (it_kind == KIND_READ) ? it_rrow : row_c;
  assign vsum = {1'b0, rem} + {1'b0, vrow};
  assign phys = (vsum >= rows) ? ROW_W'(vsum - rows) : vsum[ROW_W-1:0];

  assign bs_col = (col_c != '0) ? COL_W'(col_c - 1'b1) : '0;
  assign tcol   = is_bs ? bs_col : col_c;
  assign row_ok = row_valid[phys];

  assign rd_in_range = ({1'b0, it_rrow} < rows) && ({1'b0, it_rcol} < cols);

  assign single_wr = cmd.exec && (it_kind == KIND_TYPE) && (is_print || is_bs) && row_ok;
  assign mem_rd    = cmd.exec && sts.need_read;

  assign shifted = SH_W'(rows) << step;

  always_comb begin
    sts           = '0;
    sts.out_free  = !rsp_valid || rsp_ready;
    sts.mod_need  = ({1'b0, top} >= rows);
    sts.mod_last  = (step == '0);
    sts.need_fill = (it_kind == KIND_TYPE) && is_print && !row_ok;
    sts.need_read = (it_kind == KIND_READ) && rd_in_range && row_ok;
    sts.fill_last = &fill_cnt;
  end

  // a row that is not valid reads as blank, so it is filled before first use
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = {phys, tcol};
    mem_wdata = is_bs ? CH_BLANK : it_char;
    if (cmd.fill) begin
      mem_we    = 1'b1;
      mem_waddr = {wr_row, fill_cnt};
      mem_wdata = (fill_cnt == wr_col) ? wr_char : CH_BLANK;
    end else if (single_wr) begin
      mem_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_rd) begin
      mem_q <= mem[{phys, it_rcol}];
    end
  end

  // cursor update
  always_comb begin
    col_inc = {1'b0, col_c} + 1'b1;
    row_inc = {1'b0, row_c} + 1'b1;
    top_inc = {1'b0, rem} + 1'b1;
    nxt_col = col_c;
    nxt_row = row_c;
    nl_req  = 1'b0;
    scroll  = 1'b0;
    nxt_top = (top_inc >= rows) ? '0 : top_inc[ROW_W-1:0];
    if (it_kind == KIND_TYPE) begin
      if (is_nl) begin
        nxt_col = '0;
        nl_req  = 1'b1;
      end else if (is_cr) begin
        nxt_col = '0;
      end else if (is_bs) begin
        nxt_col = bs_col;
      end else if (col_inc >= cols) begin
        nxt_col = '0;
        nl_req  = 1'b1;
      end else begin
        nxt_col = col_inc[COL_W-1:0];
      end
    end
    if (nl_req) begin
      if (row_inc < rows) begin
        nxt_row = row_inc[ROW_W-1:0];
      end else begin
        scroll = 1'b1;
      end
    end
    if ((it_kind == KIND_READ) && rd_in_range) begin
      rd_val = row_ok ? mem_q : CH_BLANK;
    end else begin
      rd_val = '0;
    end
  end

  always_comb begin
    row_valid_next = row_valid;
    if (cmd.fill && sts.fill_last) begin
      row_valid_next[wr_row] = 1'b1;
    end
    if (cmd.finish) begin
      if (it_kind == KIND_CLEAR) begin
        row_valid_next = '0;
      end else if (scroll) begin
        // the recycled row goes blank; wins over a fill of the same row
        row_valid_next[rem] = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      num_cols  <= NUM_COLS_RST;
      num_rows  <= NUM_ROWS_RST;
      cur_col   <= '0;
      cur_row   <= '0;
      top       <= '0;
      row_valid <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_idx_t'(cfg_index))
          CFG_NUM_COLS: num_cols <= cfg_data[NCOLS_W-1:0];
          CFG_NUM_ROWS: num_rows <= cfg_data[NROWS_W-1:0];
        endcase
      end
      row_valid <= row_valid_next;
      if (cmd.finish) begin
        rsp_valid <= 1'b1;
        if (it_kind == KIND_CLEAR) begin
          cur_col <= '0;
          cur_row <= '0;
          top     <= '0;
        end else begin
          cur_col <= nxt_col;
          cur_row <= nxt_row;
          if (scroll) begin
            top <= nxt_top;
          end
        end
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      it_kind <= kind_t'(kind);
      it_char <= char_code;
      it_rrow <= read_row;
      it_rcol <= read_col;
      rem     <= top;
      step    <= STEP_W'(ROW_W - 1);
    end
    // restoring reduction of the offset modulo rows
    if (cmd.mod_step) begin
      if ({{(SH_W-ROW_W){1'b0}}, rem} >= shifted) begin
        rem <= ROW_W'({{(SH_W-ROW_W){1'b0}}, rem} - shifted);
      end
      step <= step - 1'b1;
    end
    if (cmd.exec) begin
      wr_row   <= phys;
      wr_col   <= tcol;
      wr_char  <= it_char;
      fill_cnt <= '0;
    end
    if (cmd.fill) begin
      fill_cnt <= fill_cnt + 1'b1;
    end
    if (cmd.finish) begin
      rsp_cursor_col <= (it_kind == KIND_CLEAR) ? '0 : nxt_col;
      rsp_cursor_row <= (it_kind == KIND_CLEAR) ? '0 : nxt_row;
      rsp_scrolled   <= (it_kind != KIND_CLEAR) && scroll;
      rsp_read_char  <= rd_val;
    end
  end

  `TCC_ASSERT_IMP(a_rem_reduced, clk, rst, cmd.exec, (ROW_W+1)'(rem) < rows, "ring offset not reduced before execute")
  `TCC_ASSERT_NXT(a_cursor_in_range, clk, rst, cmd.finish, (COL_W+1)'(cur_col) < $past(cols), "cursor column left the screen")
  `TCC_ASSERT_NXT(a_rsp_hold, clk, rst, rsp_valid && !rsp_ready, rsp_valid, "pending result dropped")

endmodule

// File: bench/tb.sv
`timescale 1ns / 100ps

module tb;
  import tcc_pkg::*;

  localparam int STALL_LIMIT = 5000;
  localparam int HOLD_CYCLES = 400;
  localparam int PHASES      = 9;
  localparam int PHASE_ITEMS = 160;

  typedef struct packed {
    kind_t             kind;
    logic [CHAR_W-1:0] char_code;
    logic [ROW_W-1:0]  read_row;
    logic [COL_W-1:0]  read_col;
  } console_req_t;

  typedef struct packed {
    logic [COL_W-1:0]  cursor_col;
    logic [ROW_W-1:0]  cursor_row;
    logic              scrolled;
    logic [CHAR_W-1:0] read_char;
  } console_rsp_t;

  // Screen model: tracks cursor, ring offset and cell store, queues one response per request.
  class console_scoreboard;
    logic [CHAR_W-1:0]  cells [MAX_ROWS][MAX_COLS];
    logic [COL_W-1:0]   col;
    logic [ROW_W-1:0]   row;
    logic [ROW_W-1:0]   top;
    logic [NCOLS_W-1:0] cols_reg;
    logic [NROWS_W-1:0] rows_reg;
    console_rsp_t       pending_rsp[$];
    int                 failures;

    function new();
      blank_screen();
      col = '0;
      row = '0;
      top = '0;
      cols_reg = NUM_COLS_RST;
      rows_reg = NUM_ROWS_RST;
      failures = 0;
    endfunction

    function void blank_screen();
      foreach (cells[r, c]) cells[r][c] = CH_BLANK;
    endfunction

    function int eff_cols();
      if (cols_reg == 0) return 1;
      return (cols_reg > MAX_COLS) ? MAX_COLS : int'(cols_reg);
    endfunction

    function int eff_rows();
      if (rows_reg == 0) return 1;
      return (rows_reg > MAX_ROWS) ? MAX_ROWS : int'(rows_reg);
    endfunction

    function int phys_row(int vrow, int rows);
      return (int'(top) + vrow) % rows;
    endfunction

    function int pending();
      return pending_rsp.size();
    endfunction

    function void write_reg(cfg_idx_t idx, logic [CFG_W-1:0] v);
      case (idx)
        CFG_NUM_COLS: cols_reg = v;
        CFG_NUM_ROWS: rows_reg = v[NROWS_W-1:0];
        default: ;
      endcase
    endfunction

    // Down one line; on the bottom row recycle the old top row as the new bottom row.
    function logic line_feed(int rows);
      int old_top;
      if (int'(row) + 1 < rows) begin
        row = row + 1'b1;
        return 1'b0;
      end
      old_top = int'(top) % rows;
      for (int c = 0; c < MAX_COLS; c++) cells[old_top][c] = CH_BLANK;
      top = ROW_W'((old_top + 1) % rows);
      return 1'b1;
    endfunction

    function void note_request(console_req_t r);
      console_rsp_t e;
      int cols;
      int rows;
      int next_col;
      cols = eff_cols();
      rows = eff_rows();
      e = '0;
      // cursor may sit outside a freshly shrunk screen
      if (col >= cols) col = COL_W'(cols - 1);
      if (row >= rows) row = ROW_W'(rows - 1);
      case (r.kind)
        KIND_TYPE: begin
          if (r.char_code == CH_NL) begin
            col = '0;
            e.scrolled = line_feed(rows);
          end else if (r.char_code == CH_CR) begin
            col = '0;
          end else if (r.char_code == CH_BS) begin
            if (col > 0) col = col - 1'b1;
            cells[phys_row(row, rows)][col] = CH_BLANK;
          end else begin
            cells[phys_row(row, rows)][col] = r.char_code;
            next_col = int'(col) + 1;
            if (next_col >= cols) begin
              col = '0;
              e.scrolled = line_feed(rows);
            end else begin
              col = COL_W'(next_col);
            end
          end
        end
        KIND_CLEAR: begin
          blank_screen();
          col = '0;
          row = '0;
          top = '0;
        end
        KIND_READ: begin
          if (r.read_row < rows && r.read_col < cols)
            e.read_char = cells[phys_row(r.read_row, rows)][r.read_col];
        end
        default: ;
      endcase
      e.cursor_col = col;
      e.cursor_row = row;
      pending_rsp.push_back(e);
    endfunction

    function void check_result(console_rsp_t got);
      console_rsp_t e;
      if (pending_rsp.size() == 0) begin
        failures++;
        if (failures <= 10)
          $display("%0t: response with none pending: col %0d row %0d scr %0b char %02h",
                   $realtime, got.cursor_col, got.cursor_row, got.scrolled, got.read_char);
        return;
      end
      e = pending_rsp.pop_front();
      if (got.cursor_col !== e.cursor_col || got.cursor_row !== e.cursor_row ||
          got.scrolled !== e.scrolled || got.read_char !== e.read_char) begin
        failures++;
        if (failures <= 10)
          $display("%0t: mismatch exp col %0d row %0d scr %0b char %02h, got %0d %0d %0b %02h",
                   $realtime, e.cursor_col, e.cursor_row, e.scrolled, e.read_char,
                   got.cursor_col, got.cursor_row, got.scrolled, got.read_char);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic               cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]   cfg_data;

  tcc_req_if req_ch();
  tcc_rsp_if rsp_ch();

  text_console_char_handler dut (
    .clk       (clk),
    .rst       (rst),
    .req       (req_ch),
    .rsp       (rsp_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  console_scoreboard sb = new();

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  bit hold_go = 1'b0;
  int hold_left = 0;
  int stall_cycles = 0;

  initial begin
    forever #1 clk = ~clk;
  end

  // response side: check, then pick ready for the next cycle
  initial begin
    console_rsp_t got;
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && rsp_ch.valid && rsp_ch.ready) begin
        got.cursor_col = rsp_ch.cursor_col;
        got.cursor_row = rsp_ch.cursor_row;
        got.scrolled   = rsp_ch.scrolled;
        got.read_char  = rsp_ch.read_char;
        sb.check_result(got);
      end
      if (hold_left == 0 && hold_go) begin
        hold_left = HOLD_CYCLES;
        hold_go = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  function automatic console_req_t make_req(kind_t k, int ch, int rr, int rc);
    console_req_t r;
    r.kind      = k;
    r.char_code = CHAR_W'(ch);
    r.read_row  = ROW_W'(rr);
    r.read_col  = COL_W'(rc);
    return r;
  endfunction

  // mostly typing with line control and reads of live cells; rare clears and unused kind
  function automatic console_req_t random_req();
    console_req_t r;
    int p;
    p = $urandom_range(99);
    r = make_req(KIND_TYPE, $urandom_range(255), $urandom_range(63), $urandom_range(127));
    if (p < 55) begin
      // keep the raw byte
    end else if (p < 67) begin
      r.char_code = CH_NL;
    end else if (p < 72) begin
      r.char_code = CH_CR;
    end else if (p < 79) begin
      r.char_code = CH_BS;
    end else if (p < 97) begin
      r.kind = KIND_READ;
      if ($urandom_range(9) < 8) begin
        r.read_row = ROW_W'($urandom_range(sb.eff_rows() - 1));
        r.read_col = COL_W'($urandom_range(sb.eff_cols() - 1));
      end
    end else if (p < 98) begin
      r.kind = KIND_CLEAR;
    end else begin
      r.kind = KIND_NOP;
    end
    return r;
  endfunction

  task automatic send_req(console_req_t r);
    int gap;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid     <= 1'b1;
    req_ch.kind      <= r.kind;
    req_ch.char_code <= r.char_code;
    req_ch.read_row  <= r.read_row;
    req_ch.read_col  <= r.read_col;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    sb.note_request(r);
  endtask

  task automatic drain();
    req_ch.valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  task automatic write_cfg(cfg_idx_t idx, logic [CFG_W-1:0] v);
    drain();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.write_reg(idx, v);
  endtask

  int ph_cols [PHASES] = '{80, 1, 16, 5, 128, 0, 255, 7, 40};
  int ph_rows [PHASES] = '{40, 1, 12, 3, 64, 0, 127, 2, 9};

  initial begin
    req_ch.valid     <= 1'b0;
    req_ch.kind      <= KIND_TYPE;
    req_ch.char_code <= '0;
    req_ch.read_row  <= '0;
    req_ch.read_col  <= '0;
    cfg_we    <= 1'b0;
    cfg_index <= CFG_NUM_COLS;
    cfg_data  <= '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // directed opening on the reset screen
    send_req(make_req(KIND_TYPE, 8'h41, 0, 0));
    send_req(make_req(KIND_TYPE, 8'hFF, 0, 0));
    send_req(make_req(KIND_TYPE, 8'h00, 0, 0));
    send_req(make_req(KIND_TYPE, 8'h80, 0, 0));
    send_req(make_req(KIND_TYPE, CH_BS, 0, 0));
    send_req(make_req(KIND_READ, 0, 0, 0));
    send_req(make_req(KIND_READ, 0, 0, 3));
    send_req(make_req(KIND_TYPE, CH_CR, 0, 0));
    send_req(make_req(KIND_TYPE, CH_BS, 0, 0));     // backspace at column zero
    send_req(make_req(KIND_TYPE, CH_NL, 0, 0));
    send_req(make_req(KIND_TYPE, CH_CR, 0, 0));
    send_req(make_req(KIND_READ, 8'hFF, 63, 127));  // far out of range
    send_req(make_req(KIND_READ, 0, 39, 79));
    send_req(make_req(KIND_READ, 0, 40, 0));
    send_req(make_req(KIND_READ, 0, 0, 80));
    send_req(make_req(KIND_NOP, 8'hFF, 63, 127));
    send_req(make_req(KIND_CLEAR, 0, 0, 0));
    send_req(make_req(KIND_READ, 0, 0, 0));

    for (int p = 0; p < PHASES; p++) begin
      if (p > 0) begin
        write_cfg(CFG_NUM_COLS, CFG_W'(ph_cols[p]));
        write_cfg(CFG_NUM_ROWS, CFG_W'(ph_rows[p]));
      end
      if (p < 3) begin
        send_idle_pct = 32;
        recv_idle_pct = 74;
      end else if (p < 6) begin
        send_idle_pct = 74;
        recv_idle_pct = 32;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      // long response stall while requests keep coming
      if (p == 2 || p == 6) hold_go = 1'b1;
      for (int i = 0; i < PHASE_ITEMS; i++) send_req(random_req());
    end

    drain();
    repeat (20) @(posedge clk);
    if (sb.failures == 0 && sb.pending() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
